FILE: hw/rtl/gbts_pkg.sv
// Shared types and codes for the gap buffer text store.
// Holds the request and response transaction structs and the operation and status codes.
// No dependencies; every other file of the block imports this package.
package gbts_pkg;

  // Width of a logical position, a delete count and the reported sizes.
  localparam int POS_W  = 13;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_MOVE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   count;
    logic [BYTE_W-1:0]  data_byte;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  read_byte;
    logic [POS_W-1:0]   text_size;
    logic [POS_W-1:0]   cursor;
  } rsp_t;

endpackage

FILE: hw/rtl/gbts_core.sv
// Gap buffer engine: byte store, gap pointers and the sequencer that moves the gap.
// Depends on gbts_pkg for the request and response structs and the codes.
// Each byte of the gap move is read from the single store in S_SHIFT and written at its new place in S_WRITE.
module gbts_core #(
  parameter int CAPACITY = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  gbts_pkg::req_t req,
  output logic           idle,
  input  logic           res_free,
  output logic           done,
  output gbts_pkg::rsp_t rsp
);
  import gbts_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = (PW > POS_W + 1) ? PW : POS_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_WRITE,
    S_APPLY,
    S_READ,
    S_DONE
  } state_t;

  state_t            state;
  logic [PW-1:0]     gap_begin;
  logic [PW-1:0]     gap_finish;
  logic [PW-1:0]     text_length;
  func_t             op;
  status_t           status;
  logic [PW-1:0]     target;
  logic [PW-1:0]     del_count;
  logic [BYTE_W-1:0] ins_byte;
  logic              move_left;

  logic [BYTE_W-1:0] store [CAPACITY];
  logic [BYTE_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;

  logic [CW-1:0]     pos_w;
  logic [CW-1:0]     cnt_w;
  logic [CW-1:0]     len_w;
  logic              range_bad;
  logic [PW-1:0]     gap_span;

  // Range check of a new request against the current text length.
  always_comb begin
    pos_w = CW'(req.position);
    cnt_w = CW'(req.count);
    len_w = CW'(text_length);
    case (req.func)
      FUNC_DELETE: range_bad = (pos_w + cnt_w) > len_w;
      FUNC_READ:   range_bad = pos_w >= len_w;
      default:     range_bad = pos_w > len_w;
    endcase
  end

  assign gap_span = gap_finish - gap_begin;

  // Store port control. Moving left copies the byte below the gap to the top of the gap;
  // moving right copies the byte above the gap to the bottom of the gap.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(gap_finish);
    wr_en   = 1'b0;
    wr_addr = AW'(gap_begin);
    wr_data = ins_byte;
    case (state)
      S_SHIFT: begin
        rd_en   = target != gap_begin;
        rd_addr = (target < gap_begin) ? AW'(gap_begin - 1'b1) : AW'(gap_finish);
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = move_left ? AW'(gap_finish - 1'b1) : AW'(gap_begin);
        wr_data = rd_data;
      end
      S_APPLY: begin
        wr_en = op == FUNC_INSERT;
      end
      S_READ: begin
        rd_en   = 1'b1;
        rd_addr = (target < gap_begin) ? AW'(target) : AW'(target + gap_span);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      gap_begin   <= '0;
      gap_finish  <= PW'(CAPACITY);
      text_length <= '0;
      op          <= FUNC_INSERT;
      status      <= STATUS_OK;
      move_left   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op        <= req.func;
            target    <= PW'(req.position);
            del_count <= PW'(req.count);
            ins_byte  <= req.data_byte;
            if (range_bad) begin
              status <= STATUS_INVALID;
              state  <= S_DONE;
            end else if (req.func == FUNC_INSERT && gap_finish == gap_begin) begin
              status <= STATUS_FULL;
              state  <= S_DONE;
            end else if (req.func == FUNC_READ) begin
              status <= STATUS_OK;
              state  <= S_READ;
            end else begin
              status <= STATUS_OK;
              state  <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          move_left <= target < gap_begin;
          if (target == gap_begin) begin
            state <= S_APPLY;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (move_left) begin
            gap_begin  <= gap_begin - 1'b1;
            gap_finish <= gap_finish - 1'b1;
          end else begin
            gap_begin  <= gap_begin + 1'b1;
            gap_finish <= gap_finish + 1'b1;
          end
          state <= S_SHIFT;
        end
        S_APPLY: begin
          case (op)
            FUNC_INSERT: begin
              gap_begin   <= gap_begin + 1'b1;
              text_length <= text_length + 1'b1;
            end
            FUNC_DELETE: begin
              gap_finish  <= gap_finish + del_count;
              text_length <= text_length - del_count;
            end
            default: begin
            end
          endcase
          state <= S_DONE;
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle = state == S_IDLE;
  assign done = (state == S_DONE) && res_free;

  always_comb begin
    rsp.status    = status;
    rsp.read_byte = (op == FUNC_READ && status == STATUS_OK) ? rd_data : '0;
    rsp.text_size = POS_W'(text_length);
    rsp.cursor    = POS_W'(gap_begin);
  end

endmodule

FILE: hw/rtl/gap_buffer_text_store_top.sv
// Top level of the gap buffer text store: request intake and the response register.
// Depends on gbts_pkg and instantiates gbts_core, which holds the store and the sequencer.
// One request transaction in gives exactly one response transaction out.
//
//   Channel   Direction  Handshake               Payload
//   req       in         req_valid / req_stall   req (gbts_pkg::req_t)
//   rsp       out        rsp_valid / rsp_stall   rsp (gbts_pkg::rsp_t)
//
// A read passes through S_READ and S_DONE after acceptance. Insert, delete and cursor move
// pass through S_SHIFT, S_APPLY and S_DONE, with an S_WRITE and a further S_SHIFT for every
// byte the gap travels: it is read in S_SHIFT and written at its new place in S_WRITE.
// Rejected requests (invalid or full) go straight to S_DONE. The store is not cleared at
// reset; rst restores an empty text with the gap spanning the whole store.
// req_stall stays high while a transaction is in work. A response that waits in the output
// register does not block the next request; only the following result waits for it.
module gap_buffer_text_store_top #(
  parameter int CAPACITY = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  gbts_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output gbts_pkg::rsp_t rsp
);
  import gbts_pkg::*;

  logic core_idle;
  logic core_done;
  logic res_free;
  rsp_t core_rsp;

  // New requests are taken only while the engine has nothing in work.
  assign req_stall = !core_idle;

  // The output register can take a result when it is empty or being drained this cycle.
  assign res_free = !rsp_valid || !rsp_stall;

  gbts_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (req_valid && core_idle),
    .req      (req),
    .idle     (core_idle),
    .res_free (res_free),
    .done     (core_done),
    .rsp      (core_rsp)
  );

  // Response register. The payload is loaded only when a result arrives, so it holds
  // steady while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (core_done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      rsp <= core_rsp;
    end
  end

endmodule

FILE: sim/gap_buffer_text_store_top_tb.sv
// Self-checking testbench for gap_buffer_text_store_top: edge cases and four phases of
// random local edits under varying idle and stall pressure.
// Depends on gbts_pkg and on the RTL of gap_buffer_text_store_top.
module gap_buffer_text_store_top_tb;
  import gbts_pkg::*;

  localparam int CAPACITY       = 4096;
  localparam int MAX_FIELD      = (1 << POS_W) - 1;
  // The slowest transaction drags the gap across the whole text, reading and writing each byte.
  // The limit covers that several times over, together with long stall runs.
  localparam int WATCHDOG_LIMIT = 100000;
  // Extra clocks at the end of the run, after every outstanding response has come back.
  localparam int TAIL_CYCLES    = 20;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  gap_buffer_text_store_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // Mirror of the text store: the byte array and the gap bounds, kept in step with every
  // accepted request transaction. The logical text is [0, gap_head) followed by
  // [gap_end, CAPACITY).
  logic [BYTE_W-1:0] text_mirror [CAPACITY];
  int gap_head;
  int gap_end;
  int text_len;

  // Responses the store still owes, oldest first.
  rsp_t edit_results_q [$];

  // Idle and stall probabilities in percent, changed from phase to phase.
  int send_idle_pct;
  int recv_stall_pct;

  int mismatches;
  int items_sent;
  int results_checked;
  int full_seen;
  int invalid_seen;
  int idle_cycles;

  always #6 clk = ~clk;

  // Moves the gap of the mirror so that it begins at target, exactly as the store does.
  // Moving down copies from the top so that overlapping bytes are not overwritten early.
  function automatic void slide_gap(int target);
    int gsize;
    gsize = gap_end - gap_head;
    if (target == gap_head || target > text_len) return;
    if (target < gap_head) begin
      for (int i = gap_head - 1; i >= target; i--) text_mirror[i + gsize] = text_mirror[i];
    end else begin
      for (int i = 0; i < target - gap_head; i++) begin
        text_mirror[gap_head + i] = text_mirror[gap_end + i];
      end
    end
    gap_head = target;
    gap_end  = target + gsize;
  endfunction

  // Applies one edit to the mirror and returns the response the store must give for it.
  function automatic rsp_t edit_text(req_t item);
    rsp_t res;
    int pos;
    int cnt;
    pos = int'(item.position);
    cnt = int'(item.count);
    res.status    = STATUS_OK;
    res.read_byte = '0;
    case (item.func)
      FUNC_INSERT: begin
        // The range check wins over the full check.
        if (pos > text_len) begin
          res.status = STATUS_INVALID;
        end else if (gap_end == gap_head) begin
          res.status = STATUS_FULL;
        end else begin
          slide_gap(pos);
          text_mirror[gap_head] = item.data_byte;
          gap_head++;
          text_len++;
        end
      end
      FUNC_DELETE: begin
        // The sum is taken at full width, so large fields never wrap into range.
        if (pos > text_len || pos + cnt > text_len) begin
          res.status = STATUS_INVALID;
        end else begin
          slide_gap(pos);
          gap_end  += cnt;
          text_len -= cnt;
        end
      end
      FUNC_READ: begin
        if (pos >= text_len) begin
          res.status = STATUS_INVALID;
        end else if (pos < gap_head) begin
          res.read_byte = text_mirror[pos];
        end else begin
          res.read_byte = text_mirror[pos + gap_end - gap_head];
        end
      end
      default: begin
        if (pos > text_len) res.status = STATUS_INVALID;
        else slide_gap(pos);
      end
    endcase
    res.text_size = POS_W'(text_len);
    res.cursor    = POS_W'(gap_head);
    return res;
  endfunction

  function automatic req_t make_edit(func_t f, int pos, int cnt, int data);
    req_t r;
    r.func      = f;
    r.position  = POS_W'(pos);
    r.count     = POS_W'(cnt);
    r.data_byte = BYTE_W'(data);
    return r;
  endfunction

  // Picks one random edit. Most edits are local to the cursor, as in real editing, which
  // keeps gap moves short; a few jump far, and a few are pure noise over the full fields.
  function automatic req_t pick_edit();
    int roll;
    int pos;
    int insert_pct;
    int room;
    roll = $urandom_range(99);
    if (roll < 8) begin
      return make_edit(func_t'($urandom_range(3)), $urandom_range(MAX_FIELD),
                       $urandom_range(MAX_FIELD), $urandom_range(255));
    end
    if (roll < 11) begin
      return make_edit(FUNC_MOVE, $urandom_range(text_len), $urandom_range(MAX_FIELD),
                       $urandom_range(255));
    end
    pos = gap_head + int'($urandom_range(16)) - 8;
    if (pos < 0) pos = 0;
    if (pos > text_len) pos = text_len;
    // Keep the text short so that even the far jumps stay cheap.
    insert_pct = (text_len < 200) ? 45 : 20;
    roll = (text_len == 0) ? 0 : $urandom_range(99);
    if (roll < insert_pct) begin
      return make_edit(FUNC_INSERT, pos, $urandom_range(MAX_FIELD), $urandom_range(255));
    end
    if (roll < insert_pct + 25) begin
      room = text_len - pos;
      if (room > 8) room = 8;
      return make_edit(FUNC_DELETE, pos, $urandom_range(room), $urandom_range(255));
    end
    if (roll < insert_pct + 50) begin
      return make_edit(FUNC_READ, $urandom_range(text_len - 1), $urandom_range(MAX_FIELD),
                       $urandom_range(255));
    end
    return make_edit(FUNC_MOVE, pos, $urandom_range(MAX_FIELD), $urandom_range(255));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offers one request transaction, idling first at random, and holds it until the store
  // accepts it. The expected response is worked out at the edge of acceptance.
  task automatic send_edit(req_t item);
    rsp_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    want = edit_text(item);
    edit_results_q.push_back(want);
    items_sent++;
    if (want.status == STATUS_FULL) full_seen++;
    if (want.status == STATUS_INVALID) invalid_seen++;
  endtask

  // Drops valid and holds off until every outstanding response has come back.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (edit_results_q.size() != 0) @(posedge clk);
  endtask

  // Boundary behavior on a short text: empty store, ends of the text, zero-length delete,
  // gap moves in both directions, and positions and counts at the top of their fields.
  task automatic test_edge_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_edit(make_edit(FUNC_READ, 0, 0, 0));
    send_edit(make_edit(FUNC_DELETE, 0, 0, 0));
    send_edit(make_edit(FUNC_INSERT, 1, 0, 8'h5A));
    send_edit(make_edit(FUNC_INSERT, 0, MAX_FIELD, 8'h00));
    send_edit(make_edit(FUNC_INSERT, 1, 0, 8'hFF));
    send_edit(make_edit(FUNC_INSERT, 0, 0, 8'hA5));
    send_edit(make_edit(FUNC_READ, 0, 0, 8'hFF));
    send_edit(make_edit(FUNC_READ, 1, MAX_FIELD, 0));
    send_edit(make_edit(FUNC_READ, 2, 0, 0));
    send_edit(make_edit(FUNC_READ, 3, 0, 0));
    send_edit(make_edit(FUNC_MOVE, 3, 0, 0));
    send_edit(make_edit(FUNC_MOVE, 4, 0, 0));
    send_edit(make_edit(FUNC_MOVE, 0, 0, 0));
    send_edit(make_edit(FUNC_INSERT, MAX_FIELD, 0, 8'h11));
    send_edit(make_edit(FUNC_READ, MAX_FIELD, 0, 0));
    send_edit(make_edit(FUNC_MOVE, MAX_FIELD, 0, 0));
    send_edit(make_edit(FUNC_DELETE, MAX_FIELD, MAX_FIELD, 0));
    send_edit(make_edit(FUNC_DELETE, 0, MAX_FIELD, 0));
    send_edit(make_edit(FUNC_DELETE, 2, 2, 0));
    send_edit(make_edit(FUNC_DELETE, 1, 2, 0));
    send_edit(make_edit(FUNC_READ, 0, 0, 0));
    send_edit(make_edit(FUNC_DELETE, 0, 1, 0));
    wait_for_results();
  endtask

  // One phase of random edits. Halfway through, the sender holds off until the store has
  // answered everything, so that a request also meets a completely quiet block.
  task automatic test_random_edits(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_for_results();
      send_edit(pick_edit());
    end
    wait_for_results();
  endtask

  // The receiver stalls at random, at the falling edge like every other input.
  always @(negedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Every accepted response transaction is held against the oldest outstanding one.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (edit_results_q.size() == 0) begin
        report_mismatch("response with nothing outstanding, cursor", rsp.cursor, 0);
      end else begin
        want = edit_results_q.pop_front();
        results_checked++;
        if (rsp.status !== want.status) begin
          report_mismatch("status", rsp.status, want.status);
        end
        if (rsp.read_byte !== want.read_byte) begin
          report_mismatch("read_byte", rsp.read_byte, want.read_byte);
        end
        if (rsp.text_size !== want.text_size) begin
          report_mismatch("text_size", rsp.text_size, want.text_size);
        end
        if (rsp.cursor !== want.cursor) begin
          report_mismatch("cursor", rsp.cursor, want.cursor);
        end
      end
    end
  end

  // Ends a hung run: too many cycles in a row without a transaction on either channel.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    req_valid       = 1'b0;
    req             = '0;
    rsp_stall       = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    mismatches      = 0;
    items_sent      = 0;
    results_checked = 0;
    full_seen       = 0;
    invalid_seen    = 0;
    idle_cycles     = 0;
    gap_head        = 0;
    gap_end         = CAPACITY;
    text_len        = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_random_edits(250, 0, 0);
    test_random_edits(250, 68, 0);
    test_random_edits(250, 0, 68);
    test_random_edits(250, 22, 22);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (edit_results_q.size() != 0) begin
      report_mismatch("responses never returned", 0, edit_results_q.size());
    end
    $display("Covered edge cases and 1000 random edits over four idle and stall mixes: %0d sent.",
             items_sent);
    $display("Checked %0d responses, %0d refused as full, %0d invalid, %0d mismatches.",
             results_checked, full_seen, invalid_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
